// File: src/assert_macros.svh
// Concurrent assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CRM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/crm_pkg.sv
`timescale 1ns / 1ps

package crm_pkg;

   // Request kinds on req_tuser
   localparam logic REQ_LOAD      = 1'b0;
   localparam logic REQ_TRANSLATE = 1'b1;

   localparam int FIELD_W = 32;
   localparam int STAGE_W = 3;
   localparam int SLOT_W  = 6;

   // Request tdata layout, lowest bit up
   localparam int STAGE_LSB   = 0;
   localparam int SLOT_LSB    = STAGE_LSB + STAGE_W;
   localparam int DEST_LSB    = SLOT_LSB + SLOT_W;
   localparam int SOURCE_LSB  = DEST_LSB + FIELD_W;
   localparam int SPAN_LSB    = SOURCE_LSB + FIELD_W;
   localparam int QUERY_LSB   = SPAN_LSB + FIELD_W;
   localparam int RESTART_LSB = QUERY_LSB + FIELD_W;
   localparam int REQ_USED_W  = RESTART_LSB + 1;
   localparam int REQ_TDATA_W = ((REQ_USED_W + 7) / 8) * 8;

   // Response tdata layout, lowest bit up
   localparam int MAPPED_LSB  = 0;
   localparam int MIN_LSB     = MAPPED_LSB + FIELD_W;
   localparam int RSP_TDATA_W = MIN_LSB + FIELD_W;

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   typedef struct packed {
      logic               is_load;
      logic               in_range;
      logic [STAGE_W-1:0] stage;
      logic [SLOT_W-1:0]  slot;
      logic [FIELD_W-1:0] dest;
      logic [FIELD_W-1:0] source;
      logic [FIELD_W-1:0] span;
      logic [FIELD_W-1:0] query;
      logic               restart;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

endpackage

// File: src/cascaded_range_remap_min.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Cascaded range remap with running minimum. A load request (req_tuser = 0)
// writes one entry {dest, source, span} into one stage's table and marks it
// valid; a load aimed outside NUM_STAGES x MAX_ENTRIES is acknowledged but
// changes nothing. A translate request (req_tuser = 1) walks query_value
// through every stage in order: in each stage the first valid entry, by
// index, whose range [source, source + span) holds the value replaces it
// with dest + (value - source), saturated to all ones; no match leaves it
// unchanged. Each request gets exactly one response: mapped value and the
// running minimum (restart_min clears it first), or for a load a zero
// mapped value, the current minimum and rsp_tuser = 1.
// The back end reads one table entry per cycle from a single-port
// read of the entry memory, scanning each stage's entries by index and
// ending a stage's scan early at its first hit, which adds a map step
// before the next stage; a done step then fills the output register once
// it is free. A load writes its entry in a load step and then takes the
// done step. Requests are buffered in a two-deep queue, and a finished
// response waits in an output register while the next request starts.
// After reset the block sweeps the entry memory to clear the valid marks,
// with req_tready held low.
module cascaded_range_remap_min #(
   parameter int NUM_STAGES  = 7,
   parameter int MAX_ENTRIES = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // stage_select[2:0], entry_slot[8:3], dest_start[40:9], source_start[72:41],
   // span_length[104:73], query_value[136:105], restart_min[137], zero pad
   input  logic [crm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[0]
   input  logic                              req_tuser,
   // Response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // mapped_value[31:0], running_min[63:32]
   output logic [crm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // was_load[0]
   output logic                              rsp_tuser
);
   import crm_pkg::*;

   q_head_type      head;
   back_status_type status;

   // Front: accept, classify and queue requests
   crm_front #(
      .NUM_STAGES  (NUM_STAGES),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .head       (head)
   );

   // Back: table memory, stage walk and response register
   crm_back #(
      .NUM_STAGES  (NUM_STAGES),
      .MAX_ENTRIES (MAX_ENTRIES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `CRM_ASSERT_IMP(a_pop_needs_head, clock, reset, status.pop, head.valid, "pop from empty queue")
   `CRM_ASSERT_IMP(a_no_rsp_in_clear, clock, reset, status.clearing, !rsp_tvalid, "response during clear")
   `CRM_ASSERT_IMP(a_load_maps_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31:0] == 32'd0, "load with nonzero mapped value")
   `CRM_ASSERT_NXT(a_min_bounded, clock, reset, rsp_tvalid && !rsp_tuser && !rsp_tready, rsp_tdata[63:32] <= rsp_tdata[31:0], "running min above mapped value")

endmodule

// File: src/crm_front.sv
`timescale 1ns / 1ps

module crm_front #(
   parameter int NUM_STAGES  = 7,
   parameter int MAX_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [crm_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  crm_pkg::back_status_type          status,
   output crm_pkg::q_head_type               head
);
   import crm_pkg::*;

   q_item_type               q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]       count_ff, count_in;
   q_item_type               item;
   logic                     push;
   logic                     full;

   // Unpack and classify the incoming request
   always_comb begin
      item.is_load  = (req_tuser == REQ_LOAD);
      item.stage    = req_tdata[STAGE_LSB +: STAGE_W];
      item.slot     = req_tdata[SLOT_LSB +: SLOT_W];
      item.dest     = req_tdata[DEST_LSB +: FIELD_W];
      item.source   = req_tdata[SOURCE_LSB +: FIELD_W];
      item.span     = req_tdata[SPAN_LSB +: FIELD_W];
      item.query    = req_tdata[QUERY_LSB +: FIELD_W];
      item.restart  = req_tdata[RESTART_LSB];
      item.in_range = (int'(item.stage) < NUM_STAGES) && (int'(item.slot) < MAX_ENTRIES);
   end

   assign full       = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign req_tready = !full && !status.clearing;
   assign push       = req_tvalid && req_tready;

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + Q_PTR_W'(1);
      end
      if (status.pop) begin
         rd_ptr_in = rd_ptr_ff + Q_PTR_W'(1);
      end
      case ({push, status.pop})
         2'b10:   count_in = count_ff + Q_CNT_W'(1);
         2'b01:   count_in = count_ff - Q_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// File: src/crm_back.sv
`timescale 1ns / 1ps

module crm_back #(
   parameter int NUM_STAGES  = 7,
   parameter int MAX_ENTRIES = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  crm_pkg::q_head_type               head,
   output crm_pkg::back_status_type          status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crm_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser
);
   import crm_pkg::*;

   localparam int TABLE_DEPTH = NUM_STAGES * MAX_ENTRIES;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int STG_W       = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
   localparam int SLT_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int VB          = VALUE_BITS;
   localparam int ENT_W       = 3 * VB + 1;

   localparam logic [STG_W-1:0]  STG_LAST   = STG_W'(NUM_STAGES - 1);
   localparam logic [SLT_W-1:0]  SLT_LAST   = SLT_W'(MAX_ENTRIES - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_MAP   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Entry store: {valid, dest, source, span}
   logic [ENT_W-1:0]   table_ff [TABLE_DEPTH];
   logic [ENT_W-1:0]   rd_data_ff;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [STG_W-1:0]   stage_ff, stage_in;
   logic [SLT_W-1:0]   slot_ff, slot_in;
   logic               issue_done_ff, issue_done_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;
   logic [VB-1:0]      val_ff, val_in;
   logic [VB-1:0]      off_ff, off_in;
   logic [VB-1:0]      dest_ff, dest_in;
   q_item_type         item_ff;
   logic [VB-1:0]      min_ff, min_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [FIELD_W-1:0] rsp_min_ff, rsp_min_in;
   logic               rsp_load_ff, rsp_load_in;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENT_W-1:0]   wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   logic               ent_valid;
   logic [VB-1:0]      ent_dest, ent_src, ent_span;
   logic [VB:0]        ent_hi;
   logic               hit;
   logic [VB:0]        map_sum;
   logic [VB-1:0]      min_base, min_new;
   logic               out_free;
   logic               pop;
   logic               stage_end;

   assign ent_span  = rd_data_ff[VB-1:0];
   assign ent_src   = rd_data_ff[2*VB-1:VB];
   assign ent_dest  = rd_data_ff[3*VB-1:2*VB];
   assign ent_valid = rd_data_ff[3*VB];
   assign ent_hi    = {1'b0, ent_src} + {1'b0, ent_span};
   assign hit       = pend_ff && ent_valid && (val_ff >= ent_src) && ({1'b0, val_ff} < ent_hi);
   assign map_sum   = {1'b0, dest_ff} + {1'b0, off_ff};

   assign min_base  = item_ff.restart ? '1 : min_ff;
   assign min_new   = (val_ff < min_base) ? val_ff : min_base;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.pop      = pop;

   // Write port: clearing sweep or entry load
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clear_cnt_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_LOAD) begin
         wr_en   = item_ff.in_range;
         wr_addr = ADDR_W'(int'(item_ff.stage) * MAX_ENTRIES + int'(item_ff.slot));
         wr_data = {1'b1, VB'(item_ff.dest), VB'(item_ff.source), VB'(item_ff.span)};
      end
   end

   assign rd_en   = (state_ff == ST_SCAN) && !issue_done_ff && !hit;
   assign rd_addr = ADDR_W'(int'(stage_ff) * MAX_ENTRIES + int'(slot_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      stage_in      = stage_ff;
      slot_in       = slot_ff;
      issue_done_in = issue_done_ff;
      pend_in       = rd_en;
      pend_last_in  = rd_en && (slot_ff == SLT_LAST);
      val_in        = val_ff;
      off_in        = off_ff;
      dest_in       = dest_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_load_in   = rsp_load_ff;
      stage_end     = 1'b0;

      if (rd_en) begin
         if (slot_ff == SLT_LAST) begin
            issue_done_in = 1'b1;
         end else begin
            slot_in = slot_ff + SLT_W'(1);
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
            if (clear_cnt_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               stage_in      = '0;
               slot_in       = '0;
               issue_done_in = 1'b0;
               val_in        = VB'(head.item.query);
               state_in      = head.item.is_load ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (hit) begin
               off_in   = val_ff - ent_src;
               dest_in  = ent_dest;
               state_in = ST_MAP;
            end else if (pend_ff && pend_last_ff) begin
               stage_end = 1'b1;
            end
         end
         ST_MAP: begin
            val_in    = map_sum[VB] ? '1 : map_sum[VB-1:0];
            stage_end = 1'b1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_load_in  = item_ff.is_load;
               if (item_ff.is_load) begin
                  rsp_mapped_in = '0;
                  rsp_min_in    = FIELD_W'(min_ff);
               end else begin
                  rsp_mapped_in = FIELD_W'(val_ff);
                  rsp_min_in    = FIELD_W'(min_new);
                  min_in        = min_new;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Advance to the next stage or finish the walk
      if (stage_end) begin
         if (stage_ff == STG_LAST) begin
            state_in = ST_DONE;
         end else begin
            stage_in      = stage_ff + STG_W'(1);
            slot_in       = '0;
            issue_done_in = 1'b0;
            state_in      = ST_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         pend_ff      <= 1'b0;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         pend_ff      <= pend_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff      <= stage_in;
      slot_ff       <= slot_in;
      issue_done_ff <= issue_done_in;
      pend_last_ff  <= pend_last_in;
      val_ff        <= val_in;
      off_ff        <= off_in;
      dest_ff       <= dest_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_load_ff   <= rsp_load_in;
      if (pop) begin
         item_ff <= head.item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_min_ff, rsp_mapped_ff};
   assign rsp_tuser  = rsp_load_ff;

endmodule
